/* hdl/tgyr_pkg.sv */
// types, constants and the colour table of the text glyph to yuv renderer
// no dependencies; used by every module of the block by scoped names

package tgyr_pkg;

  localparam int unsigned FontRows     = 16;
  localparam int unsigned GlyphCount   = 256;
  localparam int unsigned RowSlots     = 16;
  localparam int unsigned SlotW        = $clog2(RowSlots);
  localparam int unsigned CodeW        = $clog2(GlyphCount);
  localparam int unsigned StoreAw      = CodeW + SlotW;
  localparam int unsigned StoreDepth   = GlyphCount * RowSlots;
  localparam int unsigned RowCntW      = $clog2(FontRows);

  localparam int unsigned CellW        = 12;
  localparam int unsigned AttrW        = 8;
  localparam int unsigned NibW         = 4;
  localparam int unsigned PixW         = 8;
  localparam int unsigned AddrW        = 18;
  localparam int unsigned DataW        = 32;
  localparam int unsigned WordsPerRow  = 4;
  localparam int unsigned WordW        = $clog2(WordsPerRow);
  localparam int unsigned DivCntW      = $clog2(CellW);

  localparam int unsigned ColsW        = 7;
  localparam int unsigned StrideW      = 11;
  localparam int unsigned MarginW      = 8;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 11;

  localparam logic [CfgIdxW-1:0] CfgTextColumns = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStrideWords = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgYMargin     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgXMargin     = 2'd3;

  localparam logic [ColsW-1:0]   ColsReset    = 7'd80;
  localparam logic [StrideW-1:0] StrideReset  = 11'd320;
  localparam logic [MarginW-1:0] MarginReset  = 8'd0;

  localparam logic [DataW-1:0] LeftMask  = 32'hffff00ff;
  localparam logic [DataW-1:0] RightMask = 32'h0000ff00;

  localparam logic CmdFontWrite = 1'b0;
  localparam logic CmdDraw      = 1'b1;

  typedef struct packed {
    logic               command;
    logic [CellW-1:0]   cell_offset;
    logic [CodeW-1:0]   char_code;
    logic [AttrW-1:0]   attribute;
    logic [SlotW-1:0]   font_row;
    logic [PixW-1:0]    font_bits;
  } in_t;

  typedef struct packed {
    logic [AddrW-1:0]   word_address;
    logic [DataW-1:0]   word_data;
    logic               last_word;
  } out_t;

  typedef struct packed {
    logic               capture;
    logic               font_wr;
    logic               div_step;
    logic               scale;
    logic               mul;
    logic               base;
    logic               load_word;
    logic               row_end;
    logic               last;
    logic [WordW-1:0]   word;
    logic [SlotW-1:0]   rd_row;
  } ctrl_cmd_t;

  function automatic logic [DataW-1:0] colour_lookup(input logic [NibW-1:0] idx);
    logic [DataW-1:0] c;
    unique case (idx)
      4'd0:    c = 32'h00800080;
      4'd1:    c = 32'h1dff1d6b;
      4'd2:    c = 32'h4b554b4a;
      4'd3:    c = 32'h80808080;
      4'd4:    c = 32'h4c544cff;
      4'd5:    c = 32'h3aaa34b5;
      4'd6:    c = 32'h7140718a;
      4'd7:    c = 32'hff80ff80;
      4'd8:    c = 32'h80808080;
      4'd9:    c = 32'hc399c36a;
      4'd10:   c = 32'hd076d074;
      4'd11:   c = 32'h80808080;
      4'd12:   c = 32'h4c544cff;
      4'd13:   c = 32'h3aaa34b5;
      4'd14:   c = 32'he100e194;
      4'd15:   c = 32'hff80ff80;
      default: c = 32'h00800080;
    endcase
    return c;
  endfunction

endpackage

/* hdl/tgyr_ctrl.sv */
// controller of the text glyph to yuv renderer: sequencing fsm and counters
// depends on tgyr_pkg; drives the datapath through tgyr_pkg::ctrl_cmd_t

module tgyr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_command_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tgyr_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StScale = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StBase  = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [tgyr_pkg::DivCntW-1:0]   div_cnt_q, div_cnt_d;
  logic [tgyr_pkg::RowCntW-1:0]   row_q, row_d;
  logic [tgyr_pkg::WordW-1:0]     word_q, word_d;
  logic                           out_valid_q, out_valid_d;
  logic                           last_row, last_word, load;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign last_row    = (row_q == tgyr_pkg::RowCntW'(tgyr_pkg::FontRows - 1));
  assign last_word   = (word_q == tgyr_pkg::WordW'(tgyr_pkg::WordsPerRow - 1));
  assign load        = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    row_d     = row_q;
    word_d    = word_q;
    cmd_o     = '0;
    cmd_o.word   = word_q;
    cmd_o.rd_row = (state_q == StEmit) ?
                   (tgyr_pkg::SlotW'(row_q) + tgyr_pkg::SlotW'(1)) : '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_command_i == tgyr_pkg::CmdDraw) begin
            cmd_o.capture = 1'b1;
            div_cnt_d     = '0;
            state_d       = StDiv;
          end else begin
            cmd_o.font_wr = 1'b1;
          end
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + tgyr_pkg::DivCntW'(1);
        if (div_cnt_q == tgyr_pkg::DivCntW'(tgyr_pkg::CellW - 1)) begin
          state_d = StScale;
        end
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        state_d     = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StBase;
      end
      StBase: begin
        cmd_o.base = 1'b1;
        row_d      = '0;
        word_d     = '0;
        state_d    = StEmit;
      end
      StEmit: begin
        if (load) begin
          cmd_o.load_word = 1'b1;
          cmd_o.last      = last_row && last_word;
          word_d          = word_q + tgyr_pkg::WordW'(1);
          if (last_word) begin
            cmd_o.row_end = 1'b1;
            row_d         = row_q + tgyr_pkg::RowCntW'(1);
            if (last_row) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      div_cnt_q   <= '0;
      row_q       <= '0;
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      row_q       <= row_d;
      word_q      <= word_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hdl/tgyr_dp.sv */
// datapath of the text glyph to yuv renderer: config registers, glyph store,
// bit-serial divider, address multiplier and word packing; depends on tgyr_pkg

module tgyr_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [tgyr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tgyr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  tgyr_pkg::in_t                  in_i,
  input  tgyr_pkg::ctrl_cmd_t            cmd_i,
  output tgyr_pkg::out_t                 out_o
);

  logic [tgyr_pkg::ColsW-1:0]    cols_q;
  logic [tgyr_pkg::StrideW-1:0]  stride_q;
  logic [tgyr_pkg::MarginW-1:0]  y_margin_q;
  logic [tgyr_pkg::MarginW-1:0]  x_margin_q;

  logic [tgyr_pkg::PixW-1:0]     glyph_mem [tgyr_pkg::StoreDepth];
  logic [tgyr_pkg::PixW-1:0]     rd_q;

  logic [tgyr_pkg::CellW-1:0]    quo_q;
  logic [tgyr_pkg::ColsW-1:0]    rem_q;
  logic [tgyr_pkg::CodeW-1:0]    char_q;
  logic [tgyr_pkg::DataW-1:0]    fg_q, bg_q;
  logic [tgyr_pkg::AddrW-1:0]    ypix_q;
  logic [tgyr_pkg::AddrW-1:0]    line_q;
  logic [tgyr_pkg::PixW-1:0]     bits_q;
  tgyr_pkg::out_t                out_q;

  logic [tgyr_pkg::ColsW-1:0]    cols_eff;
  logic [tgyr_pkg::ColsW:0]      rem_sh;
  logic [tgyr_pkg::ColsW+1:0]    diff;
  logic                          q_bit;
  logic [tgyr_pkg::ColsW-1:0]    rem_next;
  logic [tgyr_pkg::AddrW+tgyr_pkg::StrideW-1:0] prod;
  logic                          left_on, right_on;
  logic [tgyr_pkg::DataW-1:0]    left_px, right_px;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= tgyr_pkg::ColsReset;
      stride_q   <= tgyr_pkg::StrideReset;
      y_margin_q <= tgyr_pkg::MarginReset;
      x_margin_q <= tgyr_pkg::MarginReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tgyr_pkg::CfgTextColumns: cols_q     <= cfg_data_i[tgyr_pkg::ColsW-1:0];
        tgyr_pkg::CfgStrideWords: stride_q   <= cfg_data_i[tgyr_pkg::StrideW-1:0];
        tgyr_pkg::CfgYMargin:     y_margin_q <= cfg_data_i[tgyr_pkg::MarginW-1:0];
        tgyr_pkg::CfgXMargin:     x_margin_q <= cfg_data_i[tgyr_pkg::MarginW-1:0];
        default: ;
      endcase
    end
  end

  // glyph store, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.font_wr) begin
      glyph_mem[{in_i.char_code, in_i.font_row}] <= in_i.font_bits;
    end
    rd_q <= glyph_mem[{char_q, cmd_i.rd_row}];
  end

  // restoring divider, one quotient bit a cycle
  assign cols_eff = (cols_q == '0) ? tgyr_pkg::ColsW'(1) : cols_q;
  assign rem_sh   = {rem_q, quo_q[tgyr_pkg::CellW-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, cols_eff};
  assign q_bit    = !diff[tgyr_pkg::ColsW+1];
  assign rem_next = q_bit ? diff[tgyr_pkg::ColsW-1:0] : rem_sh[tgyr_pkg::ColsW-1:0];

  assign prod = (tgyr_pkg::AddrW + tgyr_pkg::StrideW)'(ypix_q) *
                (tgyr_pkg::AddrW + tgyr_pkg::StrideW)'(stride_q);

  assign left_on  = bits_q[{~cmd_i.word, 1'b1}];
  assign right_on = bits_q[{~cmd_i.word, 1'b0}];
  assign left_px  = left_on  ? fg_q : bg_q;
  assign right_px = right_on ? fg_q : bg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      quo_q  <= in_i.cell_offset;
      rem_q  <= '0;
      char_q <= in_i.char_code;
      fg_q   <= tgyr_pkg::colour_lookup(in_i.attribute[tgyr_pkg::NibW-1:0]);
      bg_q   <= tgyr_pkg::colour_lookup(in_i.attribute[tgyr_pkg::AttrW-1:tgyr_pkg::NibW]);
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[tgyr_pkg::CellW-2:0], q_bit};
      rem_q <= rem_next;
    end
    if (cmd_i.scale) begin
      ypix_q <= tgyr_pkg::AddrW'(quo_q) * tgyr_pkg::AddrW'(tgyr_pkg::FontRows)
                + tgyr_pkg::AddrW'(y_margin_q);
    end
    if (cmd_i.mul) begin
      line_q <= prod[tgyr_pkg::AddrW-1:0];
    end
    if (cmd_i.base) begin
      line_q <= line_q + tgyr_pkg::AddrW'({rem_q, {tgyr_pkg::WordW{1'b0}}})
                + tgyr_pkg::AddrW'(x_margin_q);
      bits_q <= rd_q;
    end
    if (cmd_i.row_end) begin
      line_q <= line_q + tgyr_pkg::AddrW'(stride_q);
      bits_q <= rd_q;
    end
    if (cmd_i.load_word) begin
      out_q.word_address <= line_q + tgyr_pkg::AddrW'(cmd_i.word);
      out_q.word_data    <= (left_px & tgyr_pkg::LeftMask) | (right_px & tgyr_pkg::RightMask);
      out_q.last_word    <= cmd_i.last;
    end
  end

  assign out_o = out_q;

endmodule

/* hdl/text_glyph_to_yuv_renderer_unit.sv */
// top level of the text glyph to yuv renderer: controller plus datapath
// depends on tgyr_pkg, tgyr_ctrl and tgyr_dp
//
// channel  dir  handshake              payload
// cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i (register write)
// in       in   in_valid_i/in_ready_o   in_i (tgyr_pkg::in_t)
// out      out  out_valid_o/out_ready_i out_o (tgyr_pkg::out_t), one word a beat
//
// a font write gives no word and leaves the input ready for the next item
// a draw is accepted, then runs the divide steps, the scale, multiply and base address steps and then
// emits FONT_ROWS x 4 = 64 words, one word a cycle while the output is not stalled
// the output register lets the next item in while the last word still waits
// reset clears the fsm and the config registers; the glyph store keeps no reset
// a stalled output holds the word and pauses the word sequence

module text_glyph_to_yuv_renderer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tgyr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tgyr_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tgyr_pkg::in_t                  in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tgyr_pkg::out_t                 out_o
);

  tgyr_pkg::ctrl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  tgyr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_i.command),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd)
  );

  tgyr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .out_o       (out_o)
  );

endmodule

/* hdl/tgyr_checker.sv */
// port-level checks of the text glyph to yuv renderer, bound to the top level
// depends on tgyr_pkg and text_glyph_to_yuv_renderer_unit

module tgyr_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_o,
  input  tgyr_pkg::in_t                  in_i,
  input  logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  tgyr_pkg::out_t                 out_o
);

  // no word during reset
  a_no_out_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("stalled output item changed");

  // a draw blocks further items
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_i.command == tgyr_pkg::CmdDraw) |=> !in_ready_o)
    else $error("input ready right after a draw item");

  // a font write gives no word
  a_font_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_i.command == tgyr_pkg::CmdFontWrite) && !out_valid_o
    |=> !out_valid_o)
    else $error("font write produced an output item");

endmodule

bind text_glyph_to_yuv_renderer_unit tgyr_checker u_tgyr_checker (.*);

/* test/tb.sv */
// self-checking bench for text_glyph_to_yuv_renderer_unit: font loads, cell draws, register sweeps
// depends on tgyr_pkg and the rtl top level; predicts each framebuffer word and checks it in order
`timescale 1ns / 1ps

module tb;
  import tgyr_pkg::*;

  localparam int unsigned SettleCycles = 90;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned PhaseItems   = 80;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_item;
  logic                out_valid;
  logic                out_ready;
  out_t                out_word;

  logic [PixW-1:0]     glyph_rows [StoreDepth];
  logic [RowSlots-1:0] rows_loaded [GlyphCount];
  logic [CodeW-1:0]    loaded_codes [$];
  logic [ColsW-1:0]    cols_reg;
  logic [StrideW-1:0]  stride_reg;
  logic [MarginW-1:0]  ymargin_reg;
  logic [MarginW-1:0]  xmargin_reg;

  out_t pending_words [$];
  out_t head_word;
  int   errors;
  int   items_sent;
  int   stall_cycles;
  int   ready_hold;
  bit   no_idle;

  text_glyph_to_yuv_renderer_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [DataW-1:0] palette_yuv(input logic [NibW-1:0] idx);
    case (idx)
      4'd0:    palette_yuv = 32'h00800080;
      4'd1:    palette_yuv = 32'h1dff1d6b;
      4'd2:    palette_yuv = 32'h4b554b4a;
      4'd4:    palette_yuv = 32'h4c544cff;
      4'd5:    palette_yuv = 32'h3aaa34b5;
      4'd6:    palette_yuv = 32'h7140718a;
      4'd7:    palette_yuv = 32'hff80ff80;
      4'd9:    palette_yuv = 32'hc399c36a;
      4'd10:   palette_yuv = 32'hd076d074;
      4'd12:   palette_yuv = 32'h4c544cff;
      4'd13:   palette_yuv = 32'h3aaa34b5;
      4'd14:   palette_yuv = 32'he100e194;
      4'd15:   palette_yuv = 32'hff80ff80;
      default: palette_yuv = 32'h80808080;
    endcase
  endfunction

  function automatic in_t draw_item(input logic [CellW-1:0] cell_idx,
                                    input logic [CodeW-1:0] code,
                                    input logic [AttrW-1:0] attr);
    in_t item;
    item.command     = CmdDraw;
    item.cell_offset = cell_idx;
    item.char_code   = code;
    item.attribute   = attr;
    item.font_row    = SlotW'($urandom);
    item.font_bits   = PixW'($urandom);
    return item;
  endfunction

  function automatic in_t font_item(input logic [CodeW-1:0] code, input logic [SlotW-1:0] row,
                                    input logic [PixW-1:0] bits);
    in_t item;
    item.command     = CmdFontWrite;
    item.cell_offset = CellW'($urandom);
    item.char_code   = code;
    item.attribute   = AttrW'($urandom);
    item.font_row    = row;
    item.font_bits   = bits;
    return item;
  endfunction

  task automatic predict_words(input in_t item);
    int unsigned     cols;
    int unsigned     offs;
    int unsigned     base;
    int unsigned     line;
    logic [PixW-1:0] bits;
    logic [DataW-1:0] bg;
    logic [DataW-1:0] fg;
    logic [DataW-1:0] left;
    logic [DataW-1:0] right;
    out_t            word;
    if (item.command == CmdFontWrite) begin
      glyph_rows[item.char_code * RowSlots + item.font_row] = item.font_bits;
      if (&rows_loaded[item.char_code] == 1'b0) begin
        rows_loaded[item.char_code][item.font_row] = 1'b1;
        if (&rows_loaded[item.char_code]) loaded_codes.push_back(item.char_code);
      end
    end else begin
      cols = (cols_reg == '0) ? 1 : cols_reg;
      offs = item.cell_offset;
      bg   = palette_yuv(item.attribute[7:4]);
      fg   = palette_yuv(item.attribute[3:0]);
      base = ((offs / cols) * FontRows + ymargin_reg) * stride_reg + (offs % cols) * 4
             + xmargin_reg;
      for (int r = 0; r < FontRows; r++) begin
        bits = glyph_rows[item.char_code * RowSlots + r];
        line = base + r * stride_reg;
        for (int w = 0; w < WordsPerRow; w++) begin
          left  = bits[7 - 2 * w] ? fg : bg;
          right = bits[6 - 2 * w] ? fg : bg;
          word.word_address = AddrW'(line + w);
          word.word_data    = (left & LeftMask) | (right & RightMask);
          word.last_word    = (r == FontRows - 1) && (w == WordsPerRow - 1);
          pending_words.push_back(word);
        end
      end
    end
  endtask

  task automatic send_item(input in_t item);
    int gap;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_words(item);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CfgTextColumns: cols_reg    = data[ColsW-1:0];
      CfgStrideWords: stride_reg  = data[StrideW-1:0];
      CfgYMargin:     ymargin_reg = data[MarginW-1:0];
      CfgXMargin:     xmargin_reg = data[MarginW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input int cols, input int stride, input int ym, input int xm);
    drain();
    cfg_write(CfgTextColumns, CfgDataW'(cols));
    cfg_write(CfgStrideWords, CfgDataW'(stride));
    cfg_write(CfgYMargin, CfgDataW'(ym));
    cfg_write(CfgXMargin, CfgDataW'(xm));
  endtask

  task automatic load_glyph(input logic [CodeW-1:0] code);
    logic [PixW-1:0] bits;
    for (int r = 0; r < RowSlots; r++) begin
      case ($urandom_range(0, 7))
        0:       bits = '0;
        1:       bits = '1;
        default: bits = PixW'($urandom);
      endcase
      send_item(font_item(code, SlotW'(r), bits));
    end
  endtask

  task automatic random_item();
    logic [CellW-1:0] cell_idx;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      load_glyph(CodeW'($urandom));
    end else if (pick < 20) begin
      send_item(font_item(CodeW'($urandom), SlotW'($urandom), PixW'($urandom)));
    end else begin
      case ($urandom_range(0, 9))
        0:       cell_idx = '0;
        1:       cell_idx = '1;
        default: cell_idx = CellW'($urandom);
      endcase
      send_item(draw_item(cell_idx, loaded_codes[$urandom_range(0, loaded_codes.size() - 1)],
                          AttrW'($urandom)));
    end
  endtask

  task automatic test_font_load();
    logic [PixW-1:0] patterns [8] = '{8'h00, 8'hff, 8'haa, 8'h55, 8'h80, 8'h01, 8'hf0, 8'h0f};
    for (int r = 0; r < RowSlots; r++)
      send_item(font_item(8'ha5, SlotW'(r), (r < 8) ? patterns[r] : PixW'($urandom)));
  endtask

  task automatic test_reset_defaults();
    send_item(draw_item('0, 8'ha5, 8'h0f));
    send_item(draw_item('1, 8'ha5, 8'hf0));
  endtask

  task automatic test_colour_rom();
    send_item(draw_item(12'd1, 8'ha5, 8'h1e));
    send_item(draw_item(12'd81, 8'ha5, 8'h7c));
    send_item(draw_item(12'd999, 8'ha5, 8'h3a));
    send_item(draw_item(12'd2048, 8'ha5, 8'h96));
  endtask

  task automatic test_geometry_extremes();
    set_config(1, 1, 0, 0);
    send_item(draw_item('1, 8'ha5, 8'h52));
    set_config(80, 1024, 255, 255);
    send_item(draw_item('1, 8'ha5, 8'hd4));
    send_item(draw_item('0, 8'ha5, 8'h4d));
    // zero columns acts as one column
    set_config(0, 1024, 255, 0);
    send_item(draw_item(12'd4095, 8'ha5, 8'h8b));
  endtask

  task automatic test_random_traffic();
    int start;
    for (int p = 0; p < 5; p++) begin
      set_config(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 80),
                 $urandom_range(1, 1024), $urandom_range(0, 255), $urandom_range(0, 255));
      start = items_sent;
      while (items_sent - start < PhaseItems) random_item();
    end
  endtask

  task automatic test_steady_stream();
    int start;
    set_config($urandom_range(1, 80), $urandom_range(1, 1024), $urandom_range(0, 255),
               $urandom_range(0, 255));
    no_idle = 1'b1;
    start = items_sent;
    while (items_sent - start < 40) random_item();
  endtask

  initial begin
    out_ready  = 1'b0;
    ready_hold = 0;
    forever begin
      @(negedge clk);
      if (no_idle) begin
        out_ready <= 1'b1;
      end else if (ready_hold > 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        ready_hold = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t unexpected word expected none actual %h", $time, out_word);
        errors++;
      end else begin
        head_word = pending_words.pop_front();
        if (out_word.word_address !== head_word.word_address) begin
          $display("%0t word_address expected %h actual %h", $time, head_word.word_address,
                   out_word.word_address);
          errors++;
        end
        if (out_word.word_data !== head_word.word_data) begin
          $display("%0t word_data expected %h actual %h", $time, head_word.word_data,
                   out_word.word_data);
          errors++;
        end
        if (out_word.last_word !== head_word.last_word) begin
          $display("%0t last_word expected %b actual %b", $time, head_word.last_word,
                   out_word.last_word);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    in_item      = '0;
    errors       = 0;
    items_sent   = 0;
    stall_cycles = 0;
    no_idle      = 1'b0;
    cols_reg     = ColsReset;
    stride_reg   = StrideReset;
    ymargin_reg  = MarginReset;
    xmargin_reg  = MarginReset;
    for (int g = 0; g < GlyphCount; g++) rows_loaded[g] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_font_load();
    test_reset_defaults();
    test_colour_rom();
    test_geometry_extremes();
    test_random_traffic();
    test_steady_stream();
    drain();
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
